### hdl/ssl_pkg.sv
// Shared types, codes and constants for the seven-segment link sequencer.
// No dependencies; used by ssl_bit_shifter and seven_segment_link_sequencer.
package ssl_pkg;

   localparam logic [2:0] ACT_DIGIT  = 3'd0;
   localparam logic [2:0] ACT_RAW    = 3'd1;
   localparam logic [2:0] ACT_COLON  = 3'd2;
   localparam logic [2:0] ACT_ENABLE = 3'd3;
   localparam logic [2:0] ACT_BRIGHT = 3'd4;

   localparam logic [1:0] SYM_START = 2'd0;
   localparam logic [1:0] SYM_DATA  = 2'd1;
   localparam logic [1:0] SYM_ACK   = 2'd2;
   localparam logic [1:0] SYM_STOP  = 2'd3;

   localparam logic [7:0] CMD_DATA       = 8'h40;
   localparam logic [7:0] CMD_FIXED_ADDR = 8'h04;
   localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
   localparam logic [7:0] CMD_CONTROL    = 8'h80;
   localparam logic [7:0] CTRL_ON        = 8'h08;
   localparam logic [2:0] BRIGHT_MAX     = 3'd7;
   localparam logic [7:0] COLON_BIT      = 8'h80;

   localparam logic [3:0] ACK_COUNT = 4'd8;

   typedef struct packed {
      logic load;
      logic step;
   } ser_ctrl_type;

   typedef struct packed {
      logic ack_slot;
      logic bit_value;
   } ser_stat_type;

   function automatic logic [7:0] seg_lookup(input logic [7:0] digit);
      logic [7:0] seg;
      unique case (digit)
         8'd0:    seg = 8'h3F;
         8'd1:    seg = 8'h06;
         8'd2:    seg = 8'h5B;
         8'd3:    seg = 8'h4F;
         8'd4:    seg = 8'h66;
         8'd5:    seg = 8'h6D;
         8'd6:    seg = 8'h7D;
         8'd7:    seg = 8'h07;
         8'd8:    seg = 8'h7F;
         8'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

### hdl/ssl_bit_shifter.sv
// Byte serialiser: shifts one byte out LSB first, then flags the ack slot.
// Depends on ssl_pkg.
module ssl_bit_shifter
   import ssl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ser_ctrl_type ctrl,
   input  logic [7:0]   load_byte,
   output ser_stat_type stat
);

   logic [7:0] shift_ff, shift_in;
   logic [3:0] count_ff, count_in;

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (ctrl.load) begin
         shift_in = load_byte;
         count_in = '0;
      end else if (ctrl.step) begin
         shift_in = {1'b0, shift_ff[7:1]};
         count_in = count_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.bit_value = shift_ff[0];
   assign stat.ack_slot  = (count_ff == ACK_COUNT);

endmodule

### hdl/seven_segment_link_sequencer.sv
// Top level of the seven-segment link sequencer: request decode, frame sequencing
// and registered symbol output. Depends on ssl_pkg and ssl_bit_shifter.
//
// Each request becomes a stream of link symbols, one symbol per cycle while the
// consumer keeps rsp_tready high. Digit, raw segment and colon requests give 31
// symbols (a command frame, then an address and segment frame); display enable
// and brightness requests give 11 symbols (one control frame). A request is taken
// only while the sequencer is idle, so it takes no new request until every symbol of
// the current one has been issued. Reserved action codes are taken and produce nothing.
module seven_segment_link_sequencer
   import ssl_pkg::*;
#(
   parameter int DIGIT_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // action[2:0], position[4:3], value[12:5], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // symbol_kind[1:0], bit_value[2], zero
   output logic        rsp_tlast
);

   typedef enum logic [1:0] {ST_IDLE, ST_START, ST_BYTE, ST_STOP} state_type;

   state_type    state_ff, state_in;
   logic         seg_mode_ff, seg_mode_in;
   logic         frame_ff, frame_in;
   logic         byte_sel_ff, byte_sel_in;
   logic [7:0]   byte_a_ff, byte_a_in;
   logic [7:0]   byte_b_ff, byte_b_in;
   logic [7:0]   byte_c_ff, byte_c_in;
   logic         display_on_ff, display_on_in;
   logic [2:0]   bright_ff, bright_in;
   logic [7:0]   colon_ff, colon_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [2:0]   rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;

   logic [2:0]   act;
   logic [1:0]   pos;
   logic [7:0]   val;
   logic [7:0]   digit_seg;
   logic [1:0]   seg_pos;
   logic [1:0]   seg_addr;
   logic [7:0]   seg_byte;
   logic         seg_go;
   logic         cfg_go;
   logic         cfg_on;
   logic [2:0]   cfg_bright;
   logic         adv;
   logic         emit;
   logic [1:0]   emit_kind;
   logic         emit_bit;
   logic         emit_last;
   logic [7:0]   load_byte;
   ser_ctrl_type ser_ctrl;
   ser_stat_type ser_stat;

   ssl_bit_shifter u_shifter (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ser_ctrl),
      .load_byte (load_byte),
      .stat      (ser_stat)
   );

   assign act = req_tdata[2:0];
   assign pos = req_tdata[4:3];
   assign val = req_tdata[12:5];
   assign digit_seg = seg_lookup(val);
   assign adv = !rsp_valid_ff || rsp_tready;
   assign seg_addr = ({2'b00, seg_pos} >= 4'(DIGIT_COUNT)) ?
                     (seg_pos - 2'(DIGIT_COUNT)) : seg_pos;

   always_comb begin
      display_on_in = display_on_ff;
      bright_in     = bright_ff;
      colon_in      = colon_ff;
      seg_pos       = pos;
      seg_byte      = val;
      seg_go        = 1'b0;
      cfg_go        = 1'b0;
      cfg_on        = display_on_ff;
      cfg_bright    = bright_ff;
      unique case (act)
         ACT_DIGIT: begin
            seg_go = 1'b1;
            seg_byte = digit_seg;
            if (pos == 2'd1) begin
               seg_byte = digit_seg | (colon_ff & COLON_BIT);
               colon_in = seg_byte;
            end
         end
         ACT_RAW: begin
            seg_go = 1'b1;
         end
         ACT_COLON: begin
            seg_go = 1'b1;
            seg_pos = 2'd1;
            seg_byte = {(val != 8'd0), colon_ff[6:0]};
            colon_in = seg_byte;
         end
         ACT_ENABLE: begin
            cfg_go = 1'b1;
            cfg_on = (val != 8'd0);
            display_on_in = cfg_on;
         end
         ACT_BRIGHT: begin
            cfg_go = 1'b1;
            cfg_bright = (val > 8'(BRIGHT_MAX)) ? BRIGHT_MAX : val[2:0];
            bright_in = cfg_bright;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      seg_mode_in  = seg_mode_ff;
      frame_in     = frame_ff;
      byte_sel_in  = byte_sel_ff;
      byte_a_in    = byte_a_ff;
      byte_b_in    = byte_b_ff;
      byte_c_in    = byte_c_ff;
      ser_ctrl     = '0;
      load_byte    = frame_ff ? byte_b_ff : byte_a_ff;
      emit         = 1'b0;
      emit_kind    = SYM_START;
      emit_bit     = 1'b0;
      emit_last    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (seg_go || cfg_go)) begin
               state_in    = ST_START;
               seg_mode_in = seg_go;
               frame_in    = 1'b0;
               byte_a_in   = seg_go ? (CMD_DATA | CMD_FIXED_ADDR) :
                             (CMD_CONTROL | (cfg_on ? CTRL_ON : 8'h00) |
                              {5'b0, cfg_bright});
               byte_b_in   = CMD_ADDRESS | {6'b0, seg_addr};
               byte_c_in   = seg_byte;
            end
         end
         ST_START: begin
            if (adv) begin
               emit          = 1'b1;
               emit_kind     = SYM_START;
               ser_ctrl.load = 1'b1;
               byte_sel_in   = 1'b0;
               state_in      = ST_BYTE;
            end
         end
         ST_BYTE: begin
            load_byte = byte_c_ff;
            if (adv) begin
               emit      = 1'b1;
               emit_kind = ser_stat.ack_slot ? SYM_ACK : SYM_DATA;
               emit_bit  = !ser_stat.ack_slot && ser_stat.bit_value;
               if (!ser_stat.ack_slot) begin
                  ser_ctrl.step = 1'b1;
               end else if (seg_mode_ff && frame_ff && !byte_sel_ff) begin
                  ser_ctrl.load = 1'b1;
                  byte_sel_in   = 1'b1;
               end else begin
                  state_in = ST_STOP;
               end
            end
         end
         ST_STOP: begin
            if (adv) begin
               emit      = 1'b1;
               emit_kind = SYM_STOP;
               emit_last = !seg_mode_ff || frame_ff;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  frame_in = 1'b1;
                  state_in = ST_START;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {emit_bit, emit_kind};
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_a_ff   <= byte_a_in;
      byte_b_ff   <= byte_b_in;
      byte_c_ff   <= byte_c_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         seg_mode_ff   <= 1'b0;
         frame_ff      <= 1'b0;
         byte_sel_ff   <= 1'b0;
         display_on_ff <= 1'b1;
         bright_ff     <= BRIGHT_MAX;
         colon_ff      <= 8'hFF;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seg_mode_ff   <= seg_mode_in;
         frame_ff      <= frame_in;
         byte_sel_ff   <= byte_sel_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (state_ff == ST_IDLE && req_tvalid) begin
            display_on_ff <= display_on_in;
            bright_ff     <= bright_in;
            colon_ff      <= colon_in;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_last_on_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[1:0] == SYM_STOP)
      else $error("last flag on a symbol other than stop");

   a_start_then_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == SYM_START |-> state_ff == ST_BYTE)
      else $error("start symbol pending outside byte phase");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (act == ACT_DIGIT || act == ACT_RAW ||
      act == ACT_COLON || act == ACT_ENABLE || act == ACT_BRIGHT)
      |=> state_ff == ST_START)
      else $error("accepted request did not open a frame");

endmodule
